// File: hw/rtl/abs_pkg.sv
// Shared types, codes and reset values for the audio block slip controller.
package abs_pkg;

  localparam logic [1:0] REQ_MEASURE = 2'd0;
  localparam logic [1:0] REQ_BLOCK   = 2'd1;
  localparam logic [1:0] REQ_START   = 2'd2;

  localparam logic [1:0] MODE_DROP   = 2'd0;
  localparam logic [1:0] MODE_NORMAL = 2'd1;
  localparam logic [1:0] MODE_DUP    = 2'd2;

  localparam logic [2:0] REG_BLOCK_TICKS = 3'd0;
  localparam logic [2:0] REG_DRIFT_LIMIT = 3'd1;
  localparam logic [2:0] REG_SLIP_STEP   = 3'd2;
  localparam logic [2:0] REG_SLIP_FIRE   = 3'd3;
  localparam logic [2:0] REG_MARKER_MODE = 3'd4;

  localparam logic [15:0] BLOCK_TICKS_RST = 16'd1470;
  localparam logic [15:0] DRIFT_LIMIT_RST = 16'd1470;
  localparam logic [7:0]  SLIP_STEP_RST   = 8'd50;
  localparam logic [7:0]  SLIP_FIRE_RST   = 8'd100;
  localparam logic        MARKER_MODE_RST = 1'b1;

  localparam logic [8:0]  ACC_MAX = 9'h1FF;

  localparam int OFIFO_DEPTH = 4;

  typedef struct packed {
    logic [15:0] block_ticks;
    logic [15:0] drift_limit;
    logic [7:0]  slip_step;
    logic [7:0]  slip_fire;
    logic        marker_mode;
  } cfg_t;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [23:0] buffered_ticks;
    logic [31:0] now_ticks;
  } item_t;

  typedef struct packed {
    logic [31:0] send_stamp;
    logic        marker_bit;
    logic        is_repeat;
    logic        last_of_run;
  } result_t;

  typedef struct packed {
    logic [1:0] count;
    result_t    r0;
    result_t    r1;
  } push_t;

endpackage

// File: hw/rtl/audio_block_slip_controller_unit.sv
// Top level of the audio block slip controller.
//
// Usage:
//   Requests enter on in_valid/in_ready with req_type, buffered_ticks and
//   now_ticks. Start and measurement requests update state and give no
//   result; a block request gives one result, or two when a block is
//   repeated, or none when it is dropped. Results leave on
//   out_valid/out_ready, one per cycle while out_ready is high, in order.
//   Registers are written on cfg_valid/cfg_ready with cfg_index/cfg_data;
//   cfg_ready is always high. Write them only while the block is idle.
//   A request is held in the input register until the result queue has
//   space; it then updates state and pushes its results into the queue.
//   Throughput is one request per cycle while the queue has space, set
//   by the result queue draining one result per cycle, so a repeated
//   block, which gives two results, can hold up the input.
//   Reset clears the slip state, loads register defaults and empties the
//   queue. When out_ready is low the four-entry queue fills and in_ready
//   drops once it holds more than two results and a request waits in the
//   input register.
module audio_block_slip_controller_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  req_type,
  input  logic [23:0] buffered_ticks,
  input  logic [31:0] now_ticks,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] send_stamp,
  output logic        marker_bit,
  output logic        is_repeat,
  output logic        last_of_run,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  import abs_pkg::*;

  cfg_t    cfg;
  item_t   item;
  logic    in_full;
  logic    take;
  logic    space;
  push_t   push;
  result_t head;

  assign cfg_ready = 1'b1;
  assign in_ready  = !in_full || space;
  assign take      = in_full && space;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.block_ticks <= BLOCK_TICKS_RST;
      cfg.drift_limit <= DRIFT_LIMIT_RST;
      cfg.slip_step   <= SLIP_STEP_RST;
      cfg.slip_fire   <= SLIP_FIRE_RST;
      cfg.marker_mode <= MARKER_MODE_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_BLOCK_TICKS: cfg.block_ticks <= cfg_data;
        REG_DRIFT_LIMIT: cfg.drift_limit <= cfg_data;
        REG_SLIP_STEP:   cfg.slip_step   <= cfg_data[7:0];
        REG_SLIP_FIRE:   cfg.slip_fire   <= cfg_data[7:0];
        REG_MARKER_MODE: cfg.marker_mode <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_valid && in_ready) begin
      in_full <= 1'b1;
    end else if (take) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item.req_type       <= req_type;
      item.buffered_ticks <= buffered_ticks;
      item.now_ticks      <= now_ticks;
    end
  end

  abs_core u_core (
    .clk  (clk),
    .rst  (rst),
    .take (take),
    .item (item),
    .cfg  (cfg),
    .push (push)
  );

  abs_ofifo u_ofifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .space     (space),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .head      (head)
  );

  assign send_stamp  = head.send_stamp;
  assign marker_bit  = head.marker_bit;
  assign is_repeat   = head.is_repeat;
  assign last_of_run = head.last_of_run;

  a_push_only_on_take: assert property (@(posedge clk) disable iff (rst)
    push.count != 2'd0 |-> take && item.req_type == REQ_BLOCK)
    else $error("result pushed without a block request");

  a_repeat_pair: assert property (@(posedge clk) disable iff (rst)
    push.count == 2'd2 |-> push.r1.is_repeat && push.r1.last_of_run &&
                           !push.r0.is_repeat && !push.r0.last_of_run)
    else $error("repeated block pair malformed");

  a_empty_after_reset: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid right after reset");

  a_no_push_when_full: assert property (@(posedge clk) disable iff (rst)
    !space |-> push.count == 2'd0)
    else $error("result queue overrun");

endmodule

// File: hw/rtl/abs_core.sv
// Slip state registers and the single-pass update for one request.
module abs_core (
  input  logic          clk,
  input  logic          rst,
  input  logic          take,
  input  abs_pkg::item_t item,
  input  abs_pkg::cfg_t  cfg,
  output abs_pkg::push_t push
);
  import abs_pkg::*;

  logic [31:0] send_time, send_time_next;
  logic [31:0] drift, drift_next;
  logic [1:0]  slip_mode, slip_mode_next;
  logic [8:0]  slip_accum, slip_accum_next;
  logic        marker_state, marker_state_next;
  logic        period_seen, period_seen_next;

  logic [7:0]  step_eff;
  logic [9:0]  acc_sum;
  logic [8:0]  acc_sat;
  logic        fires;
  logic [8:0]  acc_less;
  logic [31:0] bt32;
  logic [31:0] lim32;
  logic [31:0] drift_dn;
  logic [31:0] drift_up;
  logic        dn_above;
  logic        up_pos;
  logic [31:0] drift_m;
  logic        m_above;
  logic [31:0] stamp1;
  logic [31:0] stamp2;

  assign step_eff = (cfg.slip_step < cfg.slip_fire) ? cfg.slip_step : cfg.slip_fire;
  assign acc_sum  = {1'b0, slip_accum} + {2'b00, step_eff};
  assign acc_sat  = (acc_sum > {1'b0, ACC_MAX}) ? ACC_MAX : acc_sum[8:0];
  assign fires    = acc_sat >= {1'b0, cfg.slip_fire};
  assign acc_less = acc_sat - {1'b0, cfg.slip_fire};

  assign bt32     = {16'd0, cfg.block_ticks};
  assign lim32    = {16'd0, cfg.drift_limit};
  assign drift_dn = drift - bt32;
  assign drift_up = drift + bt32;
  assign dn_above = !drift_dn[31] && (drift_dn > lim32);
  assign up_pos   = !drift_up[31] && (drift_up != 32'd0);

  assign drift_m  = send_time + {8'd0, item.buffered_ticks} - item.now_ticks;
  assign m_above  = !drift_m[31] && (drift_m > lim32);

  assign stamp1   = send_time + bt32;
  assign stamp2   = send_time + {15'd0, cfg.block_ticks, 1'b0};

  always_comb begin
    send_time_next    = send_time;
    drift_next        = drift;
    slip_mode_next    = slip_mode;
    slip_accum_next   = slip_accum;
    marker_state_next = marker_state;
    period_seen_next  = period_seen;
    push.count        = 2'd0;
    push.r0           = '{send_stamp: send_time, marker_bit: marker_state,
                          is_repeat: 1'b0, last_of_run: 1'b1};
    push.r1           = '{send_stamp: stamp1, marker_bit: marker_state,
                          is_repeat: 1'b1, last_of_run: 1'b1};
    if (take) begin
      unique case (item.req_type)
        REQ_START: begin
          send_time_next = item.now_ticks;
        end
        REQ_MEASURE: begin
          drift_next = drift_m;
          if (drift_m[31]) begin
            slip_mode_next = MODE_DUP;
          end else if (m_above) begin
            slip_mode_next = MODE_DROP;
          end else begin
            slip_mode_next = MODE_NORMAL;
          end
          slip_accum_next = '0;
          if (period_seen && !cfg.marker_mode) begin
            marker_state_next = 1'b0;
          end
          period_seen_next = 1'b1;
        end
        REQ_BLOCK: begin
          if (slip_mode == MODE_DROP && fires) begin
            // block is dropped, no result out
            drift_next = drift_dn;
            if (!dn_above) begin
              slip_mode_next  = MODE_NORMAL;
              slip_accum_next = acc_sat;
            end else begin
              slip_accum_next = acc_less;
            end
          end else if (slip_mode == MODE_DUP && fires) begin
            drift_next = drift_up;
            if (up_pos) begin
              slip_mode_next  = MODE_NORMAL;
              slip_accum_next = acc_sat;
            end else begin
              slip_accum_next = acc_less;
            end
            push.count          = 2'd2;
            push.r0.last_of_run = 1'b0;
            send_time_next      = stamp2;
          end else begin
            if (slip_mode == MODE_DROP || slip_mode == MODE_DUP) begin
              slip_accum_next = acc_sat;
            end
            push.count     = 2'd1;
            send_time_next = stamp1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      send_time    <= '0;
      drift        <= '0;
      slip_mode    <= MODE_NORMAL;
      slip_accum   <= '0;
      marker_state <= 1'b1;
      period_seen  <= 1'b0;
    end else begin
      send_time    <= send_time_next;
      drift        <= drift_next;
      slip_mode    <= slip_mode_next;
      slip_accum   <= slip_accum_next;
      marker_state <= marker_state_next;
      period_seen  <= period_seen_next;
    end
  end

endmodule

// File: hw/rtl/abs_ofifo.sv
// Small result queue taking up to two results a cycle and giving one.
module abs_ofifo (
  input  logic             clk,
  input  logic             rst,
  input  abs_pkg::push_t   push,
  output logic             space,
  output logic             out_valid,
  input  logic             out_ready,
  output abs_pkg::result_t head
);
  import abs_pkg::*;

  localparam int PtrW = $clog2(OFIFO_DEPTH);
  localparam int CntW = $clog2(OFIFO_DEPTH + 1);

  result_t             slots [OFIFO_DEPTH];
  logic [PtrW-1:0]     wr_ptr, wr_ptr_next;
  logic [PtrW-1:0]     rd_ptr, rd_ptr_next;
  logic [CntW-1:0]     count, count_next;
  logic                pop;
  logic [PtrW-1:0]     wr_ptr1;

  assign pop       = out_valid && out_ready;
  assign out_valid = count != '0;
  assign head      = slots[rd_ptr];
  assign space     = count <= CntW'(OFIFO_DEPTH - 2);
  assign wr_ptr1   = wr_ptr + PtrW'(1);

  always_comb begin
    wr_ptr_next = wr_ptr + PtrW'(push.count);
    rd_ptr_next = pop ? rd_ptr + PtrW'(1) : rd_ptr;
    count_next  = count + CntW'(push.count) - CntW'(pop);
  end

  always_ff @(posedge clk) begin
    if (push.count != 2'd0) begin
      slots[wr_ptr] <= push.r0;
    end
    if (push.count == 2'd2) begin
      slots[wr_ptr1] <= push.r1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr_next;
      rd_ptr <= rd_ptr_next;
      count  <= count_next;
    end
  end

endmodule

// File: bench/tb_audio_block_slip_controller_unit.sv
// Self-checking testbench for the audio block slip controller: random and directed requests, predicted block copies checked in order.
`timescale 1ns / 100ps

module tb_audio_block_slip_controller_unit;
  import abs_pkg::*;

  localparam logic [1:0] REQ_UNUSED      = 2'd3;
  localparam logic [2:0] REG_SPARE_FIRST = 3'd5;
  localparam logic [2:0] REG_SPARE_LAST  = 3'd7;
  localparam int NUM_PHASES   = 8;
  localparam int PHASE_ITEMS  = 110;
  localparam int HOLD_CYCLES  = 60;
  localparam int SETTLE       = 4;
  localparam int QUIET_LIMIT  = 1000;
  localparam int ERR_PRINTS   = 20;

  class slip_scoreboard;
    cfg_t        regs;
    logic [31:0] send_time;
    logic [31:0] drift;
    logic [1:0]  mode;
    logic [8:0]  accum;
    logic        marker;
    logic        period_seen;
    result_t     copies_due[$];
    int errors, checked, blocks, repeats, drops;

    function new();
      regs.block_ticks = BLOCK_TICKS_RST;
      regs.drift_limit = DRIFT_LIMIT_RST;
      regs.slip_step   = SLIP_STEP_RST;
      regs.slip_fire   = SLIP_FIRE_RST;
      regs.marker_mode = MARKER_MODE_RST;
      send_time   = '0;
      drift       = '0;
      mode        = MODE_NORMAL;
      accum       = '0;
      marker      = 1'b1;
      period_seen = 1'b0;
    endfunction

    function void set_reg(logic [2:0] idx, logic [15:0] data);
      case (idx)
        REG_BLOCK_TICKS: regs.block_ticks = data;
        REG_DRIFT_LIMIT: regs.drift_limit = data;
        REG_SLIP_STEP:   regs.slip_step   = data[7:0];
        REG_SLIP_FIRE:   regs.slip_fire   = data[7:0];
        REG_MARKER_MODE: regs.marker_mode = data[0];
        default: ;
      endcase
    endfunction

    function logic over_limit(logic [31:0] d);
      return !d[31] && (d > {16'd0, regs.drift_limit});
    endfunction

    function void push_copy(logic rep, logic last);
      result_t r;
      r.send_stamp  = send_time;
      r.marker_bit  = marker;
      r.is_repeat   = rep;
      r.last_of_run = last;
      copies_due.push_back(r);
      send_time += {16'd0, regs.block_ticks};
    endfunction

    function void note_request(item_t it);
      logic [7:0] step;
      logic [9:0] sum;
      case (it.req_type)
        REQ_START: send_time = it.now_ticks;
        REQ_MEASURE: begin
          drift = send_time + {8'd0, it.buffered_ticks} - it.now_ticks;
          mode = MODE_NORMAL;
          if (over_limit(drift)) mode = MODE_DROP;
          if (drift[31]) mode = MODE_DUP;
          accum = '0;
          if (period_seen && !regs.marker_mode) marker = 1'b0;
          period_seen = 1'b1;
        end
        REQ_BLOCK: begin
          blocks++;
          if (mode == MODE_NORMAL) begin
            push_copy(1'b0, 1'b1);
          end else begin
            step = (regs.slip_step < regs.slip_fire) ? regs.slip_step : regs.slip_fire;
            sum = {1'b0, accum} + {2'b0, step};
            accum = (sum > {1'b0, ACC_MAX}) ? ACC_MAX : sum[8:0];
            if (accum < {1'b0, regs.slip_fire}) begin
              push_copy(1'b0, 1'b1);
            end else if (mode == MODE_DROP) begin
              drops++;
              drift -= {16'd0, regs.block_ticks};
              if (!over_limit(drift)) mode = MODE_NORMAL;
              else accum -= {1'b0, regs.slip_fire};
            end else begin
              repeats++;
              drift += {16'd0, regs.block_ticks};
              if (!drift[31] && drift != '0) mode = MODE_NORMAL;
              else accum -= {1'b0, regs.slip_fire};
              push_copy(1'b0, 1'b0);
              push_copy(1'b1, 1'b1);
            end
          end
        end
        default: ;
      endcase
    endfunction

    function void check_copy(result_t got);
      result_t want;
      if (copies_due.size() == 0) begin
        if (errors < ERR_PRINTS) $error("unexpected copy, send_stamp %08h", got.send_stamp);
        errors++;
        return;
      end
      want = copies_due.pop_front();
      checked++;
      if (got.send_stamp !== want.send_stamp) begin
        if (errors < ERR_PRINTS)
          $error("send_stamp: expected %08h, got %08h", want.send_stamp, got.send_stamp);
        errors++;
      end
      if (got.marker_bit !== want.marker_bit) begin
        if (errors < ERR_PRINTS)
          $error("marker_bit: expected %0b, got %0b", want.marker_bit, got.marker_bit);
        errors++;
      end
      if (got.is_repeat !== want.is_repeat) begin
        if (errors < ERR_PRINTS)
          $error("is_repeat: expected %0b, got %0b", want.is_repeat, got.is_repeat);
        errors++;
      end
      if (got.last_of_run !== want.last_of_run) begin
        if (errors < ERR_PRINTS)
          $error("last_of_run: expected %0b, got %0b", want.last_of_run, got.last_of_run);
        errors++;
      end
    endfunction

    function int pending();
      return copies_due.size();
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  req_type = REQ_MEASURE;
  logic [23:0] buffered_ticks = '0;
  logic [31:0] now_ticks = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [31:0] send_stamp;
  logic        marker_bit;
  logic        is_repeat;
  logic        last_of_run;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = REG_BLOCK_TICKS;
  logic [15:0] cfg_data = '0;

  slip_scoreboard sb;
  logic rx_gaps = 1'b0;
  bit   tx_gaps;
  int   hold_req_cnt = 0;
  int   hold_served = 0;
  int   hold_left = 0;
  int   stall_left = 0;
  int   quiet_cycles = 0;
  int   items_sent = 0;
  int   reg_writes = 0;

  audio_block_slip_controller_unit DUT (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .req_type       (req_type),
    .buffered_ticks (buffered_ticks),
    .now_ticks      (now_ticks),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .send_stamp     (send_stamp),
    .marker_bit     (marker_bit),
    .is_repeat      (is_repeat),
    .last_of_run    (last_of_run),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  always #1 clk = ~clk;

  // result side: check accepted copies, then pick next ready
  always @(posedge clk) begin : rx_side
    logic take;
    if (!rst && out_valid && out_ready)
      sb.check_copy(result_t'({send_stamp, marker_bit, is_repeat, last_of_run}));
    take = 1'b1;
    if (hold_left > 0) begin
      hold_left--;
      take = 1'b0;
    end else if (hold_req_cnt != hold_served) begin
      hold_served = hold_req_cnt;
      hold_left = HOLD_CYCLES - 1;
      take = 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      take = 1'b0;
    end else if (rx_gaps && $urandom_range(0, 4) == 0) begin
      stall_left = $urandom_range(0, 4);
      take = 1'b0;
    end
    out_ready <= take;
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("timeout: no handshake for %0d cycles", quiet_cycles);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task automatic send_req(input logic [1:0] kind, input logic [23:0] ticks_in,
                          input logic [31:0] now_in);
    item_t it;
    if (tx_gaps && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_valid       <= 1'b1;
    req_type       <= kind;
    buffered_ticks <= ticks_in;
    now_ticks      <= now_in;
    do @(posedge clk); while (!in_ready);
    it.req_type       = kind;
    it.buffered_ticks = ticks_in;
    it.now_ticks      = now_in;
    sb.note_request(it);
    if (kind != REQ_UNUSED) items_sent++;
  endtask

  // request a measurement that lands on a chosen drift
  task automatic measure_for(input logic [31:0] target);
    logic [23:0] ticks;
    ticks = 24'($urandom);
    send_req(REQ_MEASURE, ticks, sb.send_time + {8'd0, ticks} - target);
  endtask

  task automatic measure_random();
    int unsigned bt;
    logic [31:0] target;
    bt = sb.regs.block_ticks;
    case ($urandom_range(0, 5))
      0, 1: target = {16'd0, sb.regs.drift_limit} + 32'd1 + $urandom_range(0, 3 * bt);
      2, 3: target = -(32'd1 + $urandom_range(0, 3 * bt));
      4: target = $urandom_range(0, sb.regs.drift_limit);
      default: target = $urandom;
    endcase
    measure_for(target);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [15:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    sb.set_reg(idx, data);
    reg_writes++;
  endtask

  // narrow registers get random upper bits, which must be ignored
  task automatic program_regs(input cfg_t c);
    logic [15:0] junk;
    junk = 16'($urandom);
    write_reg(REG_BLOCK_TICKS, c.block_ticks);
    write_reg(REG_DRIFT_LIMIT, c.drift_limit);
    write_reg(REG_SLIP_STEP, {junk[15:8], c.slip_step});
    write_reg(REG_SLIP_FIRE, {junk[7:0], c.slip_fire});
    write_reg(REG_MARKER_MODE, {junk[15:1], c.marker_mode});
    write_reg(3'($urandom_range(REG_SPARE_FIRST, REG_SPARE_LAST)), 16'($urandom));
    cfg_valid <= 1'b0;
  endtask

  task automatic run_stream();
    int n;
    int pick;
    pick = $urandom_range(0, 9);
    n = $urandom_range(1, 12);
    if (pick == 0) begin
      repeat (n) send_req(2'($urandom_range(0, 3)), 24'($urandom), $urandom);
    end else if (pick == 1) begin
      repeat (n) send_req(REQ_BLOCK, 24'($urandom), $urandom);
    end else begin
      if ($urandom_range(0, 2) == 0) send_req(REQ_START, 24'($urandom), $urandom);
      measure_random();
      repeat (n) send_req(REQ_BLOCK, 24'($urandom), $urandom);
    end
  endtask

  initial begin
    cfg_t c;
    int goal;
    bit last_phase;
    sb = new();
    tx_gaps = 1'b0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: first period must keep the marker even with clearing enabled
    c = sb.regs;
    c.marker_mode = 1'b0;
    program_regs(c);
    send_req(REQ_BLOCK, '0, '0);
    send_req(REQ_START, '1, '1);
    send_req(REQ_BLOCK, '1, '1);
    measure_for('0);
    send_req(REQ_BLOCK, 24'($urandom), $urandom);
    drain();
    c.marker_mode = MARKER_MODE_RST;
    program_regs(c);
    send_req(REQ_START, '0, '0);
    measure_for({16'd0, DRIFT_LIMIT_RST});
    send_req(REQ_BLOCK, 24'($urandom), $urandom);
    measure_for({16'd0, DRIFT_LIMIT_RST} + 32'd1);
    repeat (3) send_req(REQ_BLOCK, 24'($urandom), $urandom);
    measure_for('1);
    repeat (3) send_req(REQ_BLOCK, 24'($urandom), $urandom);
    send_req(REQ_UNUSED, '1, '1);
    measure_for(32'h8000_0000);
    repeat (2) send_req(REQ_BLOCK, 24'($urandom), $urandom);
    measure_for(32'h7FFF_FFFF);
    repeat (2) send_req(REQ_BLOCK, 24'($urandom), $urandom);
    drain();

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      last_phase = (ph == NUM_PHASES - 1);
      c.block_ticks = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(1, 65535))
                                                  : 16'($urandom_range(1, 4000));
      c.drift_limit = 16'($urandom);
      c.slip_step   = 8'($urandom_range(1, 255));
      c.slip_fire   = 8'($urandom_range(1, 255));
      c.marker_mode = 1'($urandom);
      case (ph)
        0: begin
          c.block_ticks = 16'd1;
          c.drift_limit = '0;
          c.slip_step   = 8'd255;
          c.slip_fire   = 8'd255;
          c.marker_mode = 1'b0;
        end
        1: begin
          c.block_ticks = '1;
          c.drift_limit = '1;
          c.slip_step   = 8'd1;
          c.slip_fire   = 8'd1;
          c.marker_mode = 1'b1;
        end
        2: c.slip_fire = '0;
        3: begin
          c.slip_fire = 8'($urandom_range(1, 127));
          c.slip_step = c.slip_fire + 8'($urandom_range(1, 128));
        end
        default: ;
      endcase
      program_regs(c);
      rx_gaps <= !last_phase && ($urandom_range(0, 3) != 0);

      if (ph == 1) begin
        // long result stall while requests keep coming: queue fills, input stalls
        tx_gaps = 1'b0;
        measure_for('0);
        hold_req_cnt <= hold_req_cnt + 1;
        repeat (16) send_req(REQ_BLOCK, 24'($urandom), $urandom);
      end

      goal = items_sent + PHASE_ITEMS;
      while (items_sent < goal) begin
        tx_gaps = !last_phase && ($urandom_range(0, 2) != 0);
        run_stream();
        if (!last_phase && $urandom_range(0, 19) == 0) drain();
      end
      drain();
    end

    $display("Covered %0d requests (%0d blocks) across %0d register writes;", items_sent,
             sb.blocks, reg_writes);
    $display("%0d copies checked, %0d repeats, %0d drops.", sb.checked, sb.repeats, sb.drops);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// File: sim.f
hw/rtl/abs_pkg.sv
hw/rtl/abs_core.sv
hw/rtl/abs_ofifo.sv
hw/rtl/audio_block_slip_controller_unit.sv
bench/tb_audio_block_slip_controller_unit.sv
